/* rtl/wake_cfb_stream_cipher_core_macros.svh */
// ============================================================================
// WAKE CFB stream cipher core: assertion macros
// Shared clocked assertion forms for the checker files of this block.
// ============================================================================
`ifndef WAKE_CFB_STREAM_CIPHER_CORE_MACROS_SVH
`define WAKE_CFB_STREAM_CIPHER_CORE_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define WCFB_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also applies while reset is high.
`define WCFB_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/wcfb_pkg.sv */
// ============================================================================
// WAKE CFB package
// Types, command codes and constants shared by the WAKE CFB core modules.
// ============================================================================
package wcfb_pkg;

   // Register indexes on the configuration port.
   localparam logic [2:0] REG_KEY_WORD_0  = 3'd0;
   localparam logic [2:0] REG_KEY_WORD_1  = 3'd1;
   localparam logic [2:0] REG_KEY_WORD_2  = 3'd2;
   localparam logic [2:0] REG_KEY_WORD_3  = 3'd3;
   localparam logic [2:0] REG_DECRYPT     = 3'd4;

   // Table geometry and key schedule constants.
   localparam logic [7:0]  IDX_LAST       = 8'd255;
   localparam logic [7:0]  MIX_OFFSET     = 8'd89;
   localparam logic [7:0]  MIX_LAST       = 8'd22;
   localparam logic [8:0]  PERM_X_ADDR    = 9'd33;
   localparam logic [8:0]  PERM_Z_ADDR    = 9'd59;
   localparam logic [8:0]  TABLE_TOP_ADDR = 9'd256;
   localparam logic [31:0] Z_SET_MASK     = 32'h0100_0001;
   localparam logic [31:0] BIT23_CLR_MASK = 32'hff7f_ffff;
   localparam logic [31:0] LOW24_MASK     = 32'h00ff_ffff;

   localparam logic [31:0] TT_CONST [8] = '{
      32'h726a_8f3b, 32'he69a_3b5c, 32'hd3c7_1fe5, 32'hab3c_73d2,
      32'h4d3a_8eb3, 32'h0396_d6e8, 32'h3d4c_2f7a, 32'h9ee2_7cf3
   };

   // Datapath command codes.
   localparam logic [4:0] OP_NONE      = 5'd0;
   localparam logic [4:0] OP_ACCEPT    = 5'd1;
   localparam logic [4:0] OP_FILL      = 5'd2;
   localparam logic [4:0] OP_MIX_HI    = 5'd3;
   localparam logic [4:0] OP_MIX_LO    = 5'd4;
   localparam logic [4:0] OP_MIX_WR    = 5'd5;
   localparam logic [4:0] OP_PERM_X    = 5'd6;
   localparam logic [4:0] OP_PERM_Z    = 5'd7;
   localparam logic [4:0] OP_PERM_INIT = 5'd8;
   localparam logic [4:0] OP_PERM_RD   = 5'd9;
   localparam logic [4:0] OP_PERM_WR   = 5'd10;
   localparam logic [4:0] OP_COPY_RD   = 5'd11;
   localparam logic [4:0] OP_COPY_WR   = 5'd12;
   localparam logic [4:0] OP_SH_A      = 5'd13;
   localparam logic [4:0] OP_SH_B      = 5'd14;
   localparam logic [4:0] OP_SH_C      = 5'd15;
   localparam logic [4:0] OP_SH_D      = 5'd16;
   localparam logic [4:0] OP_LOAD      = 5'd17;
   localparam logic [4:0] OP_M0        = 5'd18;
   localparam logic [4:0] OP_M1        = 5'd19;
   localparam logic [4:0] OP_M2        = 5'd20;
   localparam logic [4:0] OP_M3        = 5'd21;
   localparam logic [4:0] OP_M4        = 5'd22;

   typedef struct packed {
      logic [4:0] op;
      logic [7:0] idx;
   } cmd_type;

   typedef struct packed {
      logic out_busy;
      logic in_first;
   } sts_type;

   typedef struct packed {
      logic [3:0][31:0] key;
      logic             decrypt;
   } cfg_type;

endpackage

/* rtl/wcfb_csr.sv */
// ============================================================================
// WAKE CFB configuration registers
// Key words and mode bit behind an APB-style register port.
// ============================================================================
module wcfb_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [4:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready,
   output wcfb_pkg::cfg_type cfg
);

   logic [3:0][31:0] key_ff;
   logic [3:0][31:0] key_in;
   logic             decrypt_ff;
   logic             decrypt_in;
   logic             wr_en;
   logic [2:0]       reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx    = csr_paddr[4:2];

   always_comb begin
      key_in     = key_ff;
      decrypt_in = decrypt_ff;
      if (wr_en) begin
         unique case (reg_idx)
            wcfb_pkg::REG_KEY_WORD_0,
            wcfb_pkg::REG_KEY_WORD_1,
            wcfb_pkg::REG_KEY_WORD_2,
            wcfb_pkg::REG_KEY_WORD_3: key_in[reg_idx[1:0]] = csr_pwdata;
            wcfb_pkg::REG_DECRYPT:    decrypt_in = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         wcfb_pkg::REG_KEY_WORD_0,
         wcfb_pkg::REG_KEY_WORD_1,
         wcfb_pkg::REG_KEY_WORD_2,
         wcfb_pkg::REG_KEY_WORD_3: csr_prdata = key_ff[reg_idx[1:0]];
         wcfb_pkg::REG_DECRYPT:    csr_prdata = {31'd0, decrypt_ff};
         default:                  csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff     <= '0;
         decrypt_ff <= 1'b0;
      end else begin
         key_ff     <= key_in;
         decrypt_ff <= decrypt_in;
      end
   end

   assign cfg.key     = key_ff;
   assign cfg.decrypt = decrypt_ff;

endmodule

/* rtl/wcfb_ctrl.sv */
// ============================================================================
// WAKE CFB controller
// Sequences the table build and the four M lookups of each item.
// ============================================================================
module wcfb_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  wcfb_pkg::sts_type sts,
   output wcfb_pkg::cmd_type cmd
);

   localparam logic [4:0] ST_IDLE      = 5'd0;
   localparam logic [4:0] ST_FILL      = 5'd1;
   localparam logic [4:0] ST_MIX_A     = 5'd2;
   localparam logic [4:0] ST_MIX_B     = 5'd3;
   localparam logic [4:0] ST_MIX_C     = 5'd4;
   localparam logic [4:0] ST_PERM_X    = 5'd5;
   localparam logic [4:0] ST_PERM_Z    = 5'd6;
   localparam logic [4:0] ST_PERM_INIT = 5'd7;
   localparam logic [4:0] ST_PERM_RD   = 5'd8;
   localparam logic [4:0] ST_PERM_WR   = 5'd9;
   localparam logic [4:0] ST_COPY_RD   = 5'd10;
   localparam logic [4:0] ST_COPY_WR   = 5'd11;
   localparam logic [4:0] ST_SH_A      = 5'd12;
   localparam logic [4:0] ST_SH_B      = 5'd13;
   localparam logic [4:0] ST_SH_C      = 5'd14;
   localparam logic [4:0] ST_SH_D      = 5'd15;
   localparam logic [4:0] ST_LOAD      = 5'd16;
   localparam logic [4:0] ST_DECIDE    = 5'd17;
   localparam logic [4:0] ST_M0        = 5'd18;
   localparam logic [4:0] ST_M1        = 5'd19;
   localparam logic [4:0] ST_M2        = 5'd20;
   localparam logic [4:0] ST_M3        = 5'd21;
   localparam logic [4:0] ST_M4        = 5'd22;

   logic [4:0] state_ff;
   logic [4:0] state_in;
   logic [7:0] idx_ff;
   logic [7:0] idx_in;
   logic [7:0] idx_inc;

   assign idx_inc    = idx_ff + 8'd1;
   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      cmd.op   = wcfb_pkg::OP_NONE;
      cmd.idx  = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.op   = wcfb_pkg::OP_ACCEPT;
               idx_in   = 8'd0;
               state_in = ST_DECIDE;
            end
         end
         // The captured first flag picks between a table build and plain work.
         ST_DECIDE: begin
            state_in = sts.in_first ? ST_FILL : ST_M0;
         end
         ST_FILL: begin
            cmd.op = wcfb_pkg::OP_FILL;
            idx_in = idx_inc;
            if (idx_ff == wcfb_pkg::IDX_LAST) begin
               state_in = ST_MIX_A;
            end
         end
         ST_MIX_A: begin
            cmd.op   = wcfb_pkg::OP_MIX_HI;
            state_in = ST_MIX_B;
         end
         ST_MIX_B: begin
            cmd.op   = wcfb_pkg::OP_MIX_LO;
            state_in = ST_MIX_C;
         end
         ST_MIX_C: begin
            cmd.op = wcfb_pkg::OP_MIX_WR;
            if (idx_ff == wcfb_pkg::MIX_LAST) begin
               idx_in   = 8'd0;
               state_in = ST_PERM_X;
            end else begin
               idx_in   = idx_inc;
               state_in = ST_MIX_A;
            end
         end
         ST_PERM_X: begin
            cmd.op   = wcfb_pkg::OP_PERM_X;
            state_in = ST_PERM_Z;
         end
         ST_PERM_Z: begin
            cmd.op   = wcfb_pkg::OP_PERM_Z;
            state_in = ST_PERM_INIT;
         end
         ST_PERM_INIT: begin
            cmd.op   = wcfb_pkg::OP_PERM_INIT;
            state_in = ST_PERM_RD;
         end
         ST_PERM_RD: begin
            cmd.op   = wcfb_pkg::OP_PERM_RD;
            state_in = ST_PERM_WR;
         end
         ST_PERM_WR: begin
            cmd.op = wcfb_pkg::OP_PERM_WR;
            idx_in = idx_inc;
            state_in = (idx_ff == wcfb_pkg::IDX_LAST) ? ST_COPY_RD : ST_PERM_RD;
         end
         ST_COPY_RD: begin
            cmd.op   = wcfb_pkg::OP_COPY_RD;
            state_in = ST_COPY_WR;
         end
         ST_COPY_WR: begin
            cmd.op   = wcfb_pkg::OP_COPY_WR;
            state_in = ST_SH_A;
         end
         ST_SH_A: begin
            cmd.op   = wcfb_pkg::OP_SH_A;
            state_in = ST_SH_B;
         end
         ST_SH_B: begin
            cmd.op   = wcfb_pkg::OP_SH_B;
            state_in = ST_SH_C;
         end
         ST_SH_C: begin
            cmd.op   = wcfb_pkg::OP_SH_C;
            state_in = ST_SH_D;
         end
         ST_SH_D: begin
            cmd.op = wcfb_pkg::OP_SH_D;
            idx_in = idx_inc;
            state_in = (idx_ff == wcfb_pkg::IDX_LAST) ? ST_LOAD : ST_SH_A;
         end
         ST_LOAD: begin
            cmd.op   = wcfb_pkg::OP_LOAD;
            state_in = ST_M0;
         end
         // The result register must be free before the next output is loaded.
         ST_M0: begin
            if (!sts.out_busy) begin
               cmd.op   = wcfb_pkg::OP_M0;
               state_in = ST_M1;
            end
         end
         ST_M1: begin
            cmd.op   = wcfb_pkg::OP_M1;
            state_in = ST_M2;
         end
         ST_M2: begin
            cmd.op   = wcfb_pkg::OP_M2;
            state_in = ST_M3;
         end
         ST_M3: begin
            cmd.op   = wcfb_pkg::OP_M3;
            state_in = ST_M4;
         end
         ST_M4: begin
            cmd.op   = wcfb_pkg::OP_M4;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= 8'd0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

/* rtl/wcfb_datapath.sv */
// ============================================================================
// WAKE CFB datapath
// S-box memory, key schedule registers, chain registers and result register.
// ============================================================================
module wcfb_datapath (
   input  logic              clock,
   input  logic              reset,
   input  wcfb_pkg::cmd_type cmd,
   input  wcfb_pkg::cfg_type cfg,
   input  logic [31:0]       in_word,
   input  logic              in_first,
   output wcfb_pkg::sts_type sts,
   output logic [31:0]       out_word,
   output logic              out_valid,
   input  logic              out_ready
);

   // S-box table: one write port and one registered read port.
   logic [31:0]      mem [257];
   logic [31:0]      rd_ff;
   logic             wr_en;
   logic [8:0]       wr_addr;
   logic [31:0]      wr_data;
   logic [8:0]       rd_addr;

   logic [3:0][31:0] hist_ff;
   logic [3:0][31:0] hist_in;
   logic [31:0]      x_ff;
   logic [31:0]      x_in;
   logic [31:0]      z_ff;
   logic [31:0]      z_in;
   logic [31:0]      tmp_ff;
   logic [31:0]      tmp_in;
   logic [23:0]      hi_ff;
   logic [23:0]      hi_in;
   logic [31:0]      w_ff;
   logic [31:0]      w_in;
   logic             first_ff;
   logic             first_in;
   logic [31:0]      out_ff;
   logic [31:0]      out_in;
   logic             outv_ff;
   logic             outv_in;
   logic [3:0][31:0] chain_ff;
   logic [3:0][31:0] chain_in;

   logic [31:0]      fill_sum;
   logic [31:0]      fill_val;
   logic [31:0]      perm_x;
   logic [7:0]       sh_x;
   logic [31:0]      cipher;
   logic [31:0]      feedback;
   logic [31:0]      m_new;
   logic [31:0]      m_sum;

   assign fill_sum = hist_ff[0] + hist_ff[3];
   assign fill_val = (cmd.idx[7:2] == 6'd0) ? cfg.key[cmd.idx[1:0]]
                   : ((fill_sum >> 3) ^ wcfb_pkg::TT_CONST[fill_sum[2:0]]);
   assign perm_x   = (x_ff & wcfb_pkg::BIT23_CLR_MASK) + z_ff;
   assign sh_x     = rd_ff[7:0] ^ x_ff[7:0];
   assign cipher   = w_ff ^ chain_ff[3];
   assign feedback = cfg.decrypt ? w_ff : cipher;
   // Finishes the M function whose lookup was issued in the previous cycle.
   assign m_new    = {8'd0, hi_ff} ^ rd_ff;

   always_comb begin
      wr_en    = 1'b0;
      wr_addr  = 9'd0;
      wr_data  = rd_ff;
      rd_addr  = 9'd0;
      hist_in  = hist_ff;
      x_in     = x_ff;
      z_in     = z_ff;
      tmp_in   = tmp_ff;
      hi_in    = hi_ff;
      w_in     = w_ff;
      first_in = first_ff;
      out_in   = out_ff;
      outv_in  = outv_ff & ~out_ready;
      chain_in = chain_ff;
      m_sum    = 32'd0;
      unique case (cmd.op)
         wcfb_pkg::OP_ACCEPT: begin
            w_in     = in_word;
            first_in = in_first;
         end
         wcfb_pkg::OP_FILL: begin
            wr_en      = 1'b1;
            wr_addr    = {1'b0, cmd.idx};
            wr_data    = fill_val;
            hist_in[0] = hist_ff[1];
            hist_in[1] = hist_ff[2];
            hist_in[2] = hist_ff[3];
            hist_in[3] = fill_val;
         end
         wcfb_pkg::OP_MIX_HI: begin
            rd_addr = {1'b0, cmd.idx + wcfb_pkg::MIX_OFFSET};
         end
         wcfb_pkg::OP_MIX_LO: begin
            tmp_in  = rd_ff;
            rd_addr = {1'b0, cmd.idx};
         end
         wcfb_pkg::OP_MIX_WR: begin
            wr_en   = 1'b1;
            wr_addr = {1'b0, cmd.idx};
            wr_data = rd_ff + tmp_ff;
         end
         wcfb_pkg::OP_PERM_X: begin
            rd_addr = wcfb_pkg::PERM_X_ADDR;
         end
         wcfb_pkg::OP_PERM_Z: begin
            x_in    = rd_ff;
            rd_addr = wcfb_pkg::PERM_Z_ADDR;
         end
         wcfb_pkg::OP_PERM_INIT: begin
            z_in = (rd_ff | wcfb_pkg::Z_SET_MASK) & wcfb_pkg::BIT23_CLR_MASK;
         end
         wcfb_pkg::OP_PERM_RD: begin
            rd_addr = {1'b0, cmd.idx};
         end
         wcfb_pkg::OP_PERM_WR: begin
            x_in    = perm_x;
            wr_en   = 1'b1;
            wr_addr = {1'b0, cmd.idx};
            wr_data = (rd_ff & wcfb_pkg::LOW24_MASK) ^ perm_x;
         end
         wcfb_pkg::OP_COPY_RD: begin
            rd_addr = 9'd0;
         end
         wcfb_pkg::OP_COPY_WR: begin
            wr_en   = 1'b1;
            wr_addr = wcfb_pkg::TABLE_TOP_ADDR;
            x_in    = {24'd0, x_ff[7:0]};
         end
         wcfb_pkg::OP_SH_A: begin
            rd_addr = {1'b0, cmd.idx ^ x_ff[7:0]};
         end
         wcfb_pkg::OP_SH_B: begin
            x_in    = {24'd0, sh_x};
            rd_addr = {1'b0, sh_x};
         end
         // Swap step: entry p takes entry x, then entry x takes entry p+1.
         wcfb_pkg::OP_SH_C: begin
            wr_en   = 1'b1;
            wr_addr = {1'b0, cmd.idx};
            rd_addr = {1'b0, cmd.idx} + 9'd1;
         end
         wcfb_pkg::OP_SH_D: begin
            wr_en   = 1'b1;
            wr_addr = {1'b0, x_ff[7:0]};
         end
         wcfb_pkg::OP_LOAD: begin
            chain_in = cfg.key;
         end
         wcfb_pkg::OP_M0: begin
            out_in  = cipher;
            outv_in = 1'b1;
            m_sum   = chain_ff[0] + feedback;
            rd_addr = {1'b0, m_sum[7:0]};
            hi_in   = m_sum[31:8];
         end
         wcfb_pkg::OP_M1: begin
            chain_in[0] = m_new;
            m_sum       = chain_ff[1] + m_new;
            rd_addr     = {1'b0, m_sum[7:0]};
            hi_in       = m_sum[31:8];
         end
         wcfb_pkg::OP_M2: begin
            chain_in[1] = m_new;
            m_sum       = chain_ff[2] + m_new;
            rd_addr     = {1'b0, m_sum[7:0]};
            hi_in       = m_sum[31:8];
         end
         wcfb_pkg::OP_M3: begin
            chain_in[2] = m_new;
            m_sum       = chain_ff[3] + m_new;
            rd_addr     = {1'b0, m_sum[7:0]};
            hi_in       = m_sum[31:8];
         end
         wcfb_pkg::OP_M4: begin
            chain_in[3] = m_new;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      hist_ff  <= hist_in;
      x_ff     <= x_in;
      z_ff     <= z_in;
      tmp_ff   <= tmp_in;
      hi_ff    <= hi_in;
      w_ff     <= w_in;
      first_ff <= first_in;
      out_ff   <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outv_ff  <= 1'b0;
         chain_ff <= '0;
      end else begin
         outv_ff  <= outv_in;
         chain_ff <= chain_in;
      end
   end

   assign out_word     = out_ff;
   assign out_valid    = outv_ff;
   assign sts.out_busy = outv_ff & ~out_ready;
   assign sts.in_first = first_ff;

endmodule

/* rtl/wake_cfb_stream_cipher_core.sv */
// Order: an item is accepted, decided on and then registered as a result in M0,
//   which waits while a result stalls; a first word adds a table build first.
// Items: a new item is taken only once the last is through the four dependent
//   S-box lookups on the single read port of the table memory.
// Reset: synchronous, active high; clears control, key, mode and chain registers.
//   The S-box memory is not cleared and is valid only after the first word.
// ============================================================================
// WAKE CFB stream cipher core
// WAKE word cipher in cipher-feedback mode over 32-bit stream items.
// ============================================================================
module wake_cfb_stream_cipher_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] in_word
   input  logic        req_tuser,   // [0] first_word
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] out_word
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   wcfb_pkg::cfg_type cfg;
   wcfb_pkg::cmd_type cmd;
   wcfb_pkg::sts_type sts;

   wcfb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   wcfb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   wcfb_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cfg       (cfg),
      .in_word   (req_tdata),
      .in_first  (req_tuser),
      .sts       (sts),
      .out_word  (rsp_tdata),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready)
   );

endmodule

/* rtl/wcfb_checker.sv */
// ============================================================================
// WAKE CFB port checker
// Checks on the core's ports over time, bound to the top level.
// ============================================================================
`include "wake_cfb_stream_cipher_core_macros.svh"

module wcfb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        csr_psel,
   input logic        csr_penable,
   input logic        csr_pwrite,
   input logic [4:0]  csr_paddr,
   input logic [31:0] csr_pwdata,
   input logic [31:0] csr_prdata,
   input logic        csr_pready
);

   logic [31:0] rsp_data_ff;
   logic [4:0]  paddr_ff;
   logic [31:0] pwdata_ff;
   logic        rsp_stall;
   logic        rsp_kept;
   logic        req_take;
   logic        key_write;
   logic        readback_ok;

   // Copies of the previous cycle's port values.
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_tdata;
      paddr_ff    <= csr_paddr;
      pwdata_ff   <= csr_pwdata;
   end

   assign rsp_stall   = rsp_tvalid && !rsp_tready;
   assign rsp_kept    = rsp_tvalid && (rsp_tdata == rsp_data_ff);
   assign req_take    = req_tvalid && req_tready;
   assign key_write   = csr_psel && csr_penable && csr_pwrite && csr_pready && !csr_paddr[4];
   assign readback_ok = (csr_paddr != paddr_ff) || (csr_prdata == pwdata_ff);

   // A stalled result keeps its data.
   `WCFB_ASSERT(a_rsp_hold, clock, reset, rsp_stall |=> rsp_kept, "stalled result changed")

   // Reset leaves no result pending and the input open.
   `WCFB_ASSERT_ALWAYS(a_reset_state, clock, reset |=> !rsp_tvalid && req_tready, "reset state")

   // The core works on one item at a time.
   `WCFB_ASSERT(a_one_item, clock, reset, req_take |=> !req_tready, "item taken while busy")

   // A key word reads back what was written to it.
   `WCFB_ASSERT(a_key_readback, clock, reset, key_write |=> readback_ok, "key readback mismatch")

endmodule

bind wake_cfb_stream_cipher_core wcfb_checker u_checker (.*);
